@@ src/kpvf_pkg.sv @@
`timescale 1ns / 1ps

package kpvf_pkg;

    // Fixed field widths
    localparam int WORD_W  = 32;
    localparam int DT_W    = 16;
    localparam int MOP_W   = 33;
    localparam int PROD_W  = 66;
    localparam int WIDE_W  = 67;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_NOISE = 8'd0,
        CFG_MEAS_NOISE  = 8'd1
    } t_cfg_idx;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [MOP_W-1:0]  t_mop;

    // One axis of filter state as held in the state memory
    typedef struct packed {
        logic signed [WORD_W-1:0] pos;
        logic signed [WORD_W-1:0] vel;
        logic [WORD_W-1:0]        pvar;
        logic [WORD_W-1:0]        cov;
        logic [WORD_W-1:0]        vvar;
    } t_axis_state;

    function automatic t_wide ext_u(input logic [WORD_W-1:0] u);
        ext_u = {{(WIDE_W-WORD_W){1'b0}}, u};
    endfunction

    function automatic t_wide ext_s(input logic signed [WORD_W-1:0] s);
        ext_s = {{(WIDE_W-WORD_W){s[WORD_W-1]}}, s};
    endfunction

    // Clamp to [0, 2^32-1]
    function automatic logic [WORD_W-1:0] sat_u32(input t_wide x);
        if (x[WIDE_W-1]) begin
            sat_u32 = '0;
        end else if (|x[WIDE_W-2:WORD_W]) begin
            sat_u32 = '1;
        end else begin
            sat_u32 = x[WORD_W-1:0];
        end
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [WORD_W-1:0] sat_s32(input t_wide x);
        if (!x[WIDE_W-1] && (|x[WIDE_W-2:WORD_W-1])) begin
            sat_s32 = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (x[WIDE_W-1] && !(&x[WIDE_W-2:WORD_W-1])) begin
            sat_s32 = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            sat_s32 = x[WORD_W-1:0];
        end
    endfunction

endpackage

@@ src/kalman_position_velocity_filter.sv @@
`timescale 1ns / 1ps

// Constant-velocity Kalman filter, AXES independent axes, Q.FRAC_BITS fixed point.
// Per-axis state (position, velocity, 2x2 covariance) lives in a small synchronous
// memory; one sequencer walks the axes in turn, reading an entry, running predict and
// update through one shared 33x33 multiplier and one bit-serial divider, and writing
// the entry back. The time per item is set almost entirely by the two gain divisions
// per axis. One item is worked on at a time; a finished result waits in the output
// register while the next item is taken. Configuration writes are always accepted and
// must only be issued while the filter is idle.
module kalman_position_velocity_filter #(
    parameter int AXES      = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic [15:0]         i_dt,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_est_x,
    output logic signed [31:0]  o_est_y,
    output logic signed [31:0]  o_est_z,
    output logic signed [31:0]  o_vel_x,
    output logic signed [31:0]  o_vel_y,
    output logic signed [31:0]  o_vel_z,
    output logic [31:0]         o_var_px,
    output logic [31:0]         o_var_py,
    output logic [31:0]         o_var_pz,
    output logic [31:0]         o_var_vx,
    output logic [31:0]         o_var_vy,
    output logic [31:0]         o_var_vz
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int NW = 33 + FRAC_BITS;
    localparam int DW = 33;
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
    localparam logic [63:0] ACCEL_FULL = 64'd1000 << FRAC_BITS;
    localparam logic [31:0] ACCEL_RST = (ACCEL_FULL > 64'hFFFF_FFFF) ?
                                        32'hFFFF_FFFF : ACCEL_FULL[31:0];
    localparam logic [63:0] MEAS_FULL = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [31:0] MEAS_RST = MEAS_FULL[31:0];
    localparam kpvf_pkg::t_wide HALF_F = kpvf_pkg::t_wide'(1) <<< (FRAC_BITS - 1);
    localparam logic [NW-1:0] K1_MAX = NW'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_LD, ST_MUL, ST_ACC, ST_DIV1, ST_DIV1_W,
        ST_DIV2, ST_DIV2_W, ST_WR, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_VDT, OP_VDT2, OP_CDT, OP_QDT, OP_QH, OP_XDT,
        OP_K1R, OP_K2R, OP_K1P, OP_K1C, OP_K2C
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic [AW-1:0] r_axis;

    logic [31:0] r_accel;
    logic [31:0] r_meas_noise;

    logic signed [31:0] r_meas [AXES];
    logic [15:0]        r_dt;
    logic signed [31:0] w_in [3];

    // Working registers for the current axis
    logic signed [31:0] r_x, r_v, r_xp, r_res, r_xn, r_vn;
    logic [31:0] r_p, r_c, r_vv, r_vdt, r_qdt, r_pp, r_cp, r_vp, r_k2;
    logic [31:0] r_pn, r_cn, r_vvn;
    logic [FRAC_BITS:0] r_k1;
    logic [34:0] r_sum;
    logic [32:0] r_s;

    logic signed [65:0] r_prod;
    kpvf_pkg::t_mop w_mul_a, w_mul_b;
    kpvf_pkg::t_wide w_pw, w_rnd15, w_rnd16, w_rnd17, w_rndf;
    logic signed [31:0] w_xp, w_res;

    // Result staging and output register
    logic signed [31:0] r_est_pos [AXES];
    logic signed [31:0] r_est_vel [AXES];
    logic [31:0]        r_est_pv  [AXES];
    logic [31:0]        r_est_vv  [AXES];
    logic signed [31:0] w_fin_pos [3];
    logic signed [31:0] w_fin_vel [3];
    logic [31:0]        w_fin_pv  [3];
    logic [31:0]        w_fin_vv  [3];
    logic signed [31:0] r_out_pos [3];
    logic signed [31:0] r_out_vel [3];
    logic [31:0]        r_out_pv  [3];
    logic [31:0]        r_out_vv  [3];
    logic               r_out_valid;

    kpvf_pkg::t_axis_state w_rd_data, w_wr_data;

    logic          w_div_start;
    logic          w_div_done;
    logic [NW-1:0] w_div_num;
    logic [NW-1:0] w_div_quo;
    logic [31:0]   w_div_src;

    logic w_in_xfer, w_load_out;

    assign w_in[0] = i_pos_x;
    assign w_in[1] = i_pos_y;
    assign w_in[2] = i_pos_z;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_load_out  = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel      <= ACCEL_RST;
            r_meas_noise <= MEAS_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == kpvf_pkg::CFG_ACCEL_NOISE) begin
                r_accel <= i_cfg_data;
            end else if (i_cfg_index == kpvf_pkg::CFG_MEAS_NOISE) begin
                r_meas_noise <= i_cfg_data;
            end
        end
    end

    // Multiplier operand select
    always_comb begin
        w_mul_b = {17'b0, r_dt};
        case (r_op)
            OP_VDT:  w_mul_a = {1'b0, r_vv};
            OP_VDT2: w_mul_a = {1'b0, r_vdt};
            OP_CDT:  w_mul_a = {1'b0, r_c};
            OP_QDT:  w_mul_a = {1'b0, r_accel};
            OP_QH:   w_mul_a = {1'b0, r_qdt};
            OP_XDT:  w_mul_a = {r_v[31], r_v};
            OP_K1R: begin
                w_mul_a = 33'(r_k1);
                w_mul_b = {r_res[31], r_res};
            end
            OP_K2R: begin
                w_mul_a = {1'b0, r_k2};
                w_mul_b = {r_res[31], r_res};
            end
            OP_K1P: begin
                w_mul_a = 33'(r_k1);
                w_mul_b = {1'b0, r_pp};
            end
            OP_K1C: begin
                w_mul_a = 33'(r_k1);
                w_mul_b = {1'b0, r_cp};
            end
            OP_K2C: begin
                w_mul_a = {1'b0, r_k2};
                w_mul_b = {1'b0, r_cp};
            end
            default: w_mul_a = '0;
        endcase
    end

    // Rounded scalings of the registered product (round half up)
    always_comb begin
        w_pw    = {r_prod[65], r_prod};
        w_rnd15 = (w_pw + kpvf_pkg::t_wide'(16384)) >>> 15;
        w_rnd16 = (w_pw + kpvf_pkg::t_wide'(32768)) >>> 16;
        w_rnd17 = (w_pw + kpvf_pkg::t_wide'(65536)) >>> 17;
        w_rndf  = (w_pw + HALF_F) >>> FRAC_BITS;
        w_xp    = kpvf_pkg::sat_s32(kpvf_pkg::ext_s(r_x) + w_rnd16);
        w_res   = kpvf_pkg::sat_s32(kpvf_pkg::ext_s(r_meas[r_axis])
                                    - kpvf_pkg::ext_s(w_xp));
    end

    // Divider operands: gain numerator is (value << F) + s/2
    assign w_div_src   = (r_state == ST_DIV2) ? r_cp : r_pp;
    assign w_div_num   = (NW'(w_div_src) << FRAC_BITS) + NW'(r_s >> 1);
    assign w_div_start = ((r_state == ST_DIV1) && (r_s != '0)) || (r_state == ST_DIV2);

    kpvf_divider #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_s),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_comb begin
        w_wr_data.pos  = r_xn;
        w_wr_data.vel  = r_vn;
        w_wr_data.pvar = r_pn;
        w_wr_data.cov  = r_cn;
        w_wr_data.vvar = r_vvn;
    end

    kpvf_state_mem #(
        .DEPTH   (AXES),
        .AW      (AW),
        .RST_ONE (ONE)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == ST_RD),
        .i_rd_addr (r_axis),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_state == ST_WR),
        .i_wr_addr (r_axis),
        .i_wr_data (w_wr_data)
    );

    // Unused axes report zero
    for (genvar g = 0; g < 3; g++) begin : g_fin
        if (g < AXES) begin : g_used
            assign w_fin_pos[g] = r_est_pos[g];
            assign w_fin_vel[g] = r_est_vel[g];
            assign w_fin_pv[g]  = r_est_pv[g];
            assign w_fin_vv[g]  = r_est_vv[g];
        end else begin : g_unused
            assign w_fin_pos[g] = '0;
            assign w_fin_vel[g] = '0;
            assign w_fin_pv[g]  = '0;
            assign w_fin_vv[g]  = '0;
        end
    end

    // Sequencer: read entry, predict, gain divisions (none if s is zero), update, write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_VDT;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_prod <= w_mul_a * w_mul_b;

            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        for (int a = 0; a < AXES; a++) begin
                            r_meas[a] <= w_in[a];
                        end
                        r_dt    <= i_dt;
                        r_axis  <= '0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_LD;
                end
                ST_LD: begin
                    r_x     <= w_rd_data.pos;
                    r_v     <= w_rd_data.vel;
                    r_p     <= w_rd_data.pvar;
                    r_c     <= w_rd_data.cov;
                    r_vv    <= w_rd_data.vvar;
                    r_op    <= OP_VDT;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_state <= ST_MUL;
                    case (r_op)
                        OP_VDT: begin
                            r_vdt <= w_rnd16[31:0];
                            r_op  <= OP_VDT2;
                        end
                        OP_VDT2: begin
                            r_sum <= {3'b0, r_p} + w_rnd16[34:0];
                            r_op  <= OP_CDT;
                        end
                        OP_CDT: begin
                            r_sum <= r_sum + w_rnd15[34:0];
                            r_op  <= OP_QDT;
                        end
                        OP_QDT: begin
                            r_qdt <= w_rnd16[31:0];
                            r_op  <= OP_QH;
                        end
                        OP_QH: begin
                            r_pp <= kpvf_pkg::sat_u32({32'b0, r_sum} + w_rnd17);
                            r_cp <= kpvf_pkg::sat_u32(kpvf_pkg::ext_u(r_c)
                                                      + kpvf_pkg::ext_u(r_vdt));
                            r_vp <= kpvf_pkg::sat_u32(kpvf_pkg::ext_u(r_vv)
                                                      + kpvf_pkg::ext_u(r_qdt));
                            r_op <= OP_XDT;
                        end
                        OP_XDT: begin
                            r_xp    <= w_xp;
                            r_res   <= w_res;
                            r_s     <= {1'b0, r_pp} + {1'b0, r_meas_noise};
                            r_state <= ST_DIV1;
                        end
                        OP_K1R: begin
                            r_xn <= kpvf_pkg::sat_s32(kpvf_pkg::ext_s(r_xp) + w_rndf);
                            r_op <= OP_K2R;
                        end
                        OP_K2R: begin
                            r_vn <= kpvf_pkg::sat_s32(kpvf_pkg::ext_s(r_v) + w_rndf);
                            r_op <= OP_K1P;
                        end
                        OP_K1P: begin
                            r_pn <= kpvf_pkg::sat_u32(kpvf_pkg::ext_u(r_pp) - w_rndf);
                            r_op <= OP_K1C;
                        end
                        OP_K1C: begin
                            r_cn <= kpvf_pkg::sat_u32(kpvf_pkg::ext_u(r_cp) - w_rndf);
                            r_op <= OP_K2C;
                        end
                        OP_K2C: begin
                            r_vvn   <= kpvf_pkg::sat_u32(kpvf_pkg::ext_u(r_vp) - w_rndf);
                            r_state <= ST_WR;
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_DIV1: begin
                    // zero innovation variance: both gains zero
                    if (r_s == '0) begin
                        r_k1    <= '0;
                        r_k2    <= '0;
                        r_op    <= OP_K1R;
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_DIV1_W;
                    end
                end
                ST_DIV1_W: begin
                    if (w_div_done) begin
                        r_k1    <= (w_div_quo > K1_MAX) ? K1_MAX[FRAC_BITS:0]
                                                        : w_div_quo[FRAC_BITS:0];
                        r_state <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    r_state <= ST_DIV2_W;
                end
                ST_DIV2_W: begin
                    if (w_div_done) begin
                        r_k2    <= (|w_div_quo[NW-1:32]) ? 32'hFFFF_FFFF
                                                         : w_div_quo[31:0];
                        r_op    <= OP_K1R;
                        r_state <= ST_MUL;
                    end
                end
                ST_WR: begin
                    r_est_pos[r_axis] <= r_xn;
                    r_est_vel[r_axis] <= r_vn;
                    r_est_pv[r_axis]  <= r_pn;
                    r_est_vv[r_axis]  <= r_vvn;
                    if (r_axis == AW'(AXES - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= ST_RD;
                    end
                end
                ST_DONE: begin
                    if (w_load_out) begin
                        for (int a = 0; a < 3; a++) begin
                            r_out_pos[a] <= w_fin_pos[a];
                            r_out_vel[a] <= w_fin_vel[a];
                            r_out_pv[a]  <= w_fin_pv[a];
                            r_out_vv[a]  <= w_fin_vv[a];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_est_x  = r_out_pos[0];
    assign o_est_y  = r_out_pos[1];
    assign o_est_z  = r_out_pos[2];
    assign o_vel_x  = r_out_vel[0];
    assign o_vel_y  = r_out_vel[1];
    assign o_vel_z  = r_out_vel[2];
    assign o_var_px = r_out_pv[0];
    assign o_var_py = r_out_pv[1];
    assign o_var_pz = r_out_pv[2];
    assign o_var_vx = r_out_vv[0];
    assign o_var_vy = r_out_vv[1];
    assign o_var_vz = r_out_vv[2];

endmodule

@@ src/kpvf_state_mem.sv @@
`timescale 1ns / 1ps

module kpvf_state_mem #(
    parameter int          DEPTH   = 3,
    parameter int          AW      = 2,
    parameter logic [31:0] RST_ONE = 32'h0001_0000
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [AW-1:0]          i_rd_addr,
    output kpvf_pkg::t_axis_state  o_rd_data,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  kpvf_pkg::t_axis_state  i_wr_data
);

    kpvf_pkg::t_axis_state r_mem [DEPTH];
    kpvf_pkg::t_axis_state r_rd_data;
    logic [DEPTH-1:0]      r_vld;
    kpvf_pkg::t_axis_state w_rst;

    // Entry value before its first write
    always_comb begin
        w_rst.pos  = '0;
        w_rst.vel  = '0;
        w_rst.pvar = RST_ONE;
        w_rst.cov  = '0;
        w_rst.vvar = RST_ONE;
    end

    // Storage and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : w_rst;
        end
    end

    // Written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/kpvf_divider.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module kpvf_divider #(
    parameter int NW = 49,
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_num <= {r_num[NW-2:0], 1'b0};
                r_quo <= {r_quo[NW-2:0], w_ge};
                r_rem <= w_ge ? DW'(w_trial - {1'b0, r_den}) : w_trial[DW-1:0];
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_quo;

endmodule

@@ src/kpvf_checker.sv @@
`timescale 1ns / 1ps

module kpvf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic signed [31:0]  o_est_x,
    input logic signed [31:0]  o_vel_x,
    input logic [31:0]         o_var_px,
    input logic [31:0]         o_var_vz
);

    logic [1:0] r_pend;
    logic       w_in_xfer, w_out_xfer;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = o_out_valid && i_out_ready;

    // Items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_xfer} - {1'b0, w_out_xfer};
        end
    end

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_est_x)
            && $stable(o_vel_x) && $stable(o_var_px) && $stable(o_var_vz))
        else $error("result changed while stalled");

    // One item in work at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_in_ready)
        else $error("input taken while busy");

    // Every result belongs to a taken item
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 2'd0)
        else $error("result without item");

    // Reset empties the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind kalman_position_velocity_filter kpvf_checker u_kpvf_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    typedef logic [127:0]        t_u128;
    typedef logic signed [127:0] t_s128;

    localparam t_u128 U32_MAX      = 128'hFFFF_FFFF;
    localparam t_s128 S32_MAX      = 128'sh7FFF_FFFF;
    localparam t_s128 S32_MIN      = -128'sh8000_0000;
    localparam int    FRAC         = 16;
    localparam int    DT_FRAC      = 16;
    localparam int    STALL_LIMIT  = 10000;
    localparam int    DRAIN_CYCLES = 500;
    // Register index past the last one; the block ignores it
    localparam logic [7:0] CFG_UNUSED_IDX = 8'hFF;

    typedef struct {
        logic [31:0] est [3];
        logic [31:0] vel [3];
        logic [31:0] pvar [3];
        logic [31:0] vvar [3];
    } t_estimate;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic [15:0] i_dt;
    logic        o_out_valid;
    logic        i_out_ready;
    logic signed [31:0] o_est_x, o_est_y, o_est_z;
    logic signed [31:0] o_vel_x, o_vel_y, o_vel_z;
    logic [31:0] o_var_px, o_var_py, o_var_pz;
    logic [31:0] o_var_vx, o_var_vy, o_var_vz;

    kalman_position_velocity_filter u_top (.*);

    // Filter model state and register copies
    t_u128 accel_q, meas_r;
    t_s128 trk_pos [3];
    t_s128 trk_vel [3];
    t_u128 trk_pvar [3];
    t_u128 trk_cov [3];
    t_u128 trk_vvar [3];

    t_estimate pending_estimates [$];
    bit        failed;
    bit        no_gaps;
    int        idle_cycles = 0;
    int        out_stall = 0;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_u128 round_u(t_u128 x, int n);
        return (x + (t_u128'(1) << (n - 1))) >> n;
    endfunction

    // Round to nearest, ties toward plus infinity
    function automatic t_s128 round_s(t_s128 x, int n);
        return (x + (t_s128'(1) << (n - 1))) >>> n;
    endfunction

    function automatic t_u128 clamp_u(t_u128 x);
        return (x > U32_MAX) ? U32_MAX : x;
    endfunction

    function automatic t_s128 clamp_s(t_s128 x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic t_s128 apply_gain(t_u128 k, t_s128 v);
        t_s128 mag;
        t_s128 prod;
        mag  = (v < 0) ? -v : v;
        prod = t_s128'(k) * mag;
        return round_s((v < 0) ? -prod : prod, FRAC);
    endfunction

    function automatic void filter_reset();
        accel_q = clamp_u(t_u128'(1000) << FRAC);
        meas_r  = ((t_u128'(1) << FRAC) + 500) / 1000;
        for (int a = 0; a < 3; a++) begin
            trk_pos[a]  = 0;
            trk_vel[a]  = 0;
            trk_pvar[a] = t_u128'(1) << FRAC;
            trk_cov[a]  = 0;
            trk_vvar[a] = t_u128'(1) << FRAC;
        end
    endfunction

    // Predict and correct one axis, then record its part of the estimate
    function automatic void track_axis(int a, logic signed [31:0] meas, logic [15:0] dt,
                                       inout t_estimate e);
        t_u128 dtu, vdt, vdt2, cdt2, qdt, qh, pp, cp, vp, s, k1, k2, dp, dc, dv;
        t_s128 xp, vel, res;
        dtu  = t_u128'(dt);
        vdt  = round_u(trk_vvar[a] * dtu, DT_FRAC);
        vdt2 = round_u(vdt * dtu, DT_FRAC);
        cdt2 = round_u(2 * trk_cov[a] * dtu, DT_FRAC);
        qdt  = round_u(accel_q * dtu, DT_FRAC);
        qh   = round_u(qdt * dtu, DT_FRAC + 1);
        pp   = clamp_u(trk_pvar[a] + cdt2 + vdt2 + qh);
        cp   = clamp_u(trk_cov[a] + vdt);
        vp   = clamp_u(trk_vvar[a] + qdt);
        xp   = clamp_s(trk_pos[a] + round_s(trk_vel[a] * t_s128'(dtu), DT_FRAC));
        vel  = trk_vel[a];
        s    = pp + meas_r;
        k1   = 0;
        k2   = 0;
        // Zero innovation variance leaves both gains at zero
        if (s != 0) begin
            k1 = ((pp << FRAC) + s / 2) / s;
            if (k1 > (t_u128'(1) << FRAC)) k1 = t_u128'(1) << FRAC;
            k2 = clamp_u(((cp << FRAC) + s / 2) / s);
        end
        res = clamp_s(t_s128'(meas) - xp);
        trk_pos[a] = clamp_s(xp + apply_gain(k1, res));
        trk_vel[a] = clamp_s(vel + apply_gain(k2, res));
        dp = round_u(k1 * pp, FRAC);
        dc = round_u(k1 * cp, FRAC);
        dv = round_u(k2 * cp, FRAC);
        trk_pvar[a] = (dp > pp) ? 0 : pp - dp;
        trk_cov[a]  = (dc > cp) ? 0 : cp - dc;
        trk_vvar[a] = (dv > vp) ? 0 : vp - dv;
        e.est[a]  = trk_pos[a][31:0];
        e.vel[a]  = trk_vel[a][31:0];
        e.pvar[a] = trk_pvar[a][31:0];
        e.vvar[a] = trk_vvar[a][31:0];
    endfunction

    function automatic void predict_estimate(logic signed [31:0] px, logic signed [31:0] py,
                                             logic signed [31:0] pz, logic [15:0] dt);
        t_estimate e;
        track_axis(0, px, dt, e);
        track_axis(1, py, dt, e);
        track_axis(2, pz, dt, e);
        pending_estimates.push_back(e);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endfunction

    // Result side: random stalls, compare each transfer with the oldest estimate
    always @(posedge i_clk) begin
        t_estimate e;
        int stall;
        stall = out_stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_estimates.size() == 0) begin
                    $display("%0t: result with no estimate pending", $time);
                    failed = 1'b1;
                end else begin
                    e = pending_estimates.pop_front();
                    check_field("est_x", e.est[0], o_est_x);
                    check_field("est_y", e.est[1], o_est_y);
                    check_field("est_z", e.est[2], o_est_z);
                    check_field("vel_x", e.vel[0], o_vel_x);
                    check_field("vel_y", e.vel[1], o_vel_y);
                    check_field("vel_z", e.vel[2], o_vel_z);
                    check_field("var_px", e.pvar[0], o_var_px);
                    check_field("var_py", e.pvar[1], o_var_py);
                    check_field("var_pz", e.pvar[2], o_var_pz);
                    check_field("var_vx", e.vvar[0], o_var_vx);
                    check_field("var_vy", e.vvar[1], o_var_vy);
                    check_field("var_vz", e.vvar[2], o_var_vz);
                end
                stall = no_gaps ? 0 : $urandom_range(0, 15);
            end else if (stall > 0) begin
                stall = stall - 1;
            end
            out_stall   = stall;
            i_out_ready <= (stall == 0);
        end
    end

    // Watchdog: cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic [15:0] dt);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_pos_x    <= px;
        i_pos_y    <= py;
        i_pos_z    <= pz;
        i_dt       <= dt;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_estimate(px, py, pz, dt);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == kpvf_pkg::CFG_ACCEL_NOISE) accel_q = t_u128'(data);
        else if (idx == kpvf_pkg::CFG_MEAS_NOISE) meas_r = t_u128'(data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Default noise settings, straight after reset
    task automatic test_defaults();
        send_item(32'sd65536, -32'sd65536, 32'sd0, 16'd655);
        send_item(32'sd66000, -32'sd66000, 32'sd300, 16'd655);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 16'hFFFF);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 16'd0);
        send_item(32'sd0, 32'sd0, 32'sd0, 16'd1);
    endtask

    // Field and register extremes, saturation, zero innovation, ignored index
    task automatic test_extremes();
        wait_idle();
        write_reg(kpvf_pkg::CFG_ACCEL_NOISE, 32'hFFFF_FFFF);
        write_reg(kpvf_pkg::CFG_MEAS_NOISE, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_IDX, 32'h1234_5678);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);
        send_item(32'sd0, 32'sd0, 32'sd0, 16'd0);
        wait_idle();
        // Tiny noise: gains near one, covariance shrinks toward zero
        write_reg(kpvf_pkg::CFG_ACCEL_NOISE, 32'd0);
        write_reg(kpvf_pkg::CFG_MEAS_NOISE, 32'd1);
        for (int i = 0; i < 6; i++)
            send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd65536 * i, 16'd0);
        wait_idle();
        // Innovation variance can reach zero once p collapses
        write_reg(kpvf_pkg::CFG_MEAS_NOISE, 32'd0);
        for (int i = 0; i < 5; i++)
            send_item(32'sd100 * i, -32'sd100 * i, 32'sh7FFF_FFFF, 16'd0);
        send_item(32'sh8000_0000, 32'sd0, 32'sd0, 16'hFFFF);
    endtask

    // Well-formed tracks with noisy measurements, plus some wild items
    task automatic test_random_tracks();
        logic [31:0] q_set [5] = '{32'd65536000, 32'd0, 32'hFFFF_FFFF, 32'd655, 32'd0};
        logic [31:0] r_set [5] = '{32'd66, 32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd0};
        int unsigned truth [3];
        int signed   speed [3];
        logic [15:0] dt;
        logic signed [31:0] m [3];
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            if (ph == 4) begin
                q_set[4] = $urandom;
                r_set[4] = $urandom;
            end
            write_reg(kpvf_pkg::CFG_ACCEL_NOISE, q_set[ph]);
            write_reg(kpvf_pkg::CFG_MEAS_NOISE, r_set[ph]);
            for (int a = 0; a < 3; a++) begin
                truth[a] = $urandom;
                speed[a] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            end
            for (int i = 0; i < 140; i++) begin
                no_gaps = ((i / 30) % 3 == 1);
                if ($urandom_range(0, 9) < 8) begin
                    dt = 16'($urandom_range(300, 1000));
                    for (int a = 0; a < 3; a++) begin
                        truth[a] = truth[a] + ((speed[a] * int'(dt)) >>> 16);
                        m[a] = $signed(truth[a]) + $signed($urandom_range(0, 2000)) - 1000;
                    end
                end else begin
                    dt = 16'($urandom);
                    for (int a = 0; a < 3; a++) m[a] = $urandom;
                end
                send_item(m[0], m[1], m[2], dt);
            end
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        failed      = 1'b0;
        no_gaps     = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pos_z     <= '0;
        i_dt        <= '0;
        filter_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_extremes();
        test_random_tracks();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && pending_estimates.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
